### design/jsts_pkg.sv
// ----------------------------------------------------------------------------
// jsts_pkg
// shared types, character codes and literal tables for the token scanner
// ----------------------------------------------------------------------------
package jsts_pkg;

    // one input request: a buffer byte with its position
    typedef struct packed {
        logic        start_scan;
        logic [15:0] position;
        logic [7:0]  byte_value;
        logic [16:0] buffer_length;
    } item_t;

    // one result request
    typedef struct packed {
        logic        scan_status;
        logic [2:0]  value_kind;
        logic [15:0] token_offset;
        logic [16:0] token_length;
        logic [15:0] resume_offset;
    } result_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_BLANK    = 4'd1,
        PH_STRING   = 4'd2,
        PH_ESCAPE   = 4'd3,
        PH_HEX1     = 4'd4,
        PH_HEX2     = 4'd5,
        PH_HEX3     = 4'd6,
        PH_HEX4     = 4'd7,
        PH_STR_DONE = 4'd8,
        PH_NUMBER   = 4'd9,
        PH_LITERAL  = 4'd10
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  lit_kind;
        logic [2:0]  lit_index;
        logic [15:0] token_start;
    } scan_state_t;

    localparam logic [2:0] KIND_STRING = 3'd0;
    localparam logic [2:0] KIND_NUMBER = 3'd1;
    localparam logic [2:0] KIND_TRUE   = 3'd2;
    localparam logic [2:0] KIND_FALSE  = 3'd3;
    localparam logic [2:0] KIND_NULL   = 3'd4;
    localparam logic [2:0] KIND_OBJECT = 3'd5;
    localparam logic [2:0] KIND_ARRAY  = 3'd6;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    localparam logic       STATUS_TOKEN = 1'b0;
    localparam logic       STATUS_ERROR = 1'b1;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_U = 8'h75;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // literal lengths: true 4, false 5, null 4
    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        logic [2:0] len;
        case (kind)
            LIT_TRUE:  len = 3'd4;
            LIT_FALSE: len = 3'd5;
            LIT_NULL:  len = 3'd4;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    // expected character of a literal; zero past the end of the text
    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (kind)
            LIT_TRUE:
                case (idx)
                    3'd0:    ch = 8'h74;
                    3'd1:    ch = 8'h72;
                    3'd2:    ch = 8'h75;
                    3'd3:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            LIT_FALSE:
                case (idx)
                    3'd0:    ch = 8'h66;
                    3'd1:    ch = 8'h61;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h73;
                    3'd4:    ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            LIT_NULL:
                case (idx)
                    3'd0:    ch = 8'h6E;
                    3'd1:    ch = 8'h75;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h6C;
                    default: ch = 8'h00;
                endcase
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### design/jsts_scan_fsm.sv
// ----------------------------------------------------------------------------
// jsts_scan_fsm
// scan state registers and the per-byte step logic of the token scanner
// ----------------------------------------------------------------------------
module jsts_scan_fsm
    import jsts_pkg::*;
#(
    parameter int BUFFER_BYTES = 65536
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    output logic    emit,
    output result_t result
);

    // cap above the 17-bit range never bites, so saturate it there
    localparam int          CapInt = (BUFFER_BYTES > 131071) ? 131071 : BUFFER_BYTES;
    localparam logic [16:0] BufCap = 17'(CapInt);

    scan_state_t state_reg;
    scan_state_t state_next;

    logic [16:0] blen;
    logic [16:0] pos_ext;
    logic [16:0] pos_inc;
    phase_t      cur_phase;
    phase_t      cont_phase;
    logic [15:0] ts_new;
    logic [1:0]  lk_new;
    logic [2:0]  li_new;
    logic        ev_fail;
    logic        ev_done;
    logic        ev_open;
    logic [2:0]  ev_kind;
    logic [7:0]  c;

    assign blen    = (item.buffer_length > BufCap) ? BufCap : item.buffer_length;
    assign pos_ext = {1'b0, item.position};
    assign pos_inc = pos_ext + 17'd1;
    assign c       = item.byte_value;

    // decode one byte against the current phase
    always_comb
    begin
        cur_phase  = item.start_scan ? PH_BLANK : state_reg.phase;
        ts_new     = item.start_scan ? item.position : state_reg.token_start;
        cont_phase = cur_phase;
        lk_new     = state_reg.lit_kind;
        li_new     = state_reg.lit_index;
        ev_fail    = 1'b0;
        ev_done    = 1'b0;
        ev_open    = 1'b0;
        ev_kind    = KIND_STRING;
        if (cur_phase != PH_IDLE) begin
            if (pos_ext >= blen) begin
                ev_fail = 1'b1;
            end else begin
                unique case (cur_phase)
                    PH_BLANK:
                    begin
                        ts_new = item.position;
                        if (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
                            cont_phase = PH_BLANK;
                        end else if (c == CH_LBRACE) begin
                            ev_open = 1'b1;
                            ev_kind = KIND_OBJECT;
                        end else if (c == CH_LBRACK) begin
                            ev_open = 1'b1;
                            ev_kind = KIND_ARRAY;
                        end else if (c == CH_QUOTE) begin
                            cont_phase = PH_STRING;
                        end else if (is_digit(c)) begin
                            cont_phase = PH_NUMBER;
                        end else if (c inside {CH_LOWER_T, CH_LOWER_F, CH_LOWER_N}) begin
                            lk_new     = (c == CH_LOWER_T) ? LIT_TRUE :
                                         (c == CH_LOWER_F) ? LIT_FALSE : LIT_NULL;
                            li_new     = 3'd1;
                            cont_phase = PH_LITERAL;
                        end else begin
                            ev_fail = 1'b1;
                        end
                    end
                    PH_STRING:
                    begin
                        if (c == CH_BSLASH) begin
                            cont_phase = PH_ESCAPE;
                        end else if (c == CH_QUOTE) begin
                            cont_phase = PH_STR_DONE;
                        end
                    end
                    PH_ESCAPE:
                    begin
                        if (c == CH_LOWER_U) begin
                            cont_phase = PH_HEX1;
                        end else if (c inside {CH_LOWER_B, CH_LOWER_F, CH_LOWER_T,
                                               CH_LOWER_R, CH_LOWER_N, CH_SLASH,
                                               CH_QUOTE, CH_BSLASH}) begin
                            cont_phase = PH_STRING;
                        end else begin
                            ev_fail = 1'b1;
                        end
                    end
                    PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4:
                    begin
                        if (!is_hex(c)) begin
                            ev_fail = 1'b1;
                        end else begin
                            unique case (cur_phase)
                                PH_HEX1: cont_phase = PH_HEX2;
                                PH_HEX2: cont_phase = PH_HEX3;
                                PH_HEX3: cont_phase = PH_HEX4;
                                default: cont_phase = PH_STRING;
                            endcase
                        end
                    end
                    PH_STR_DONE:
                    begin
                        ev_done = 1'b1;
                        ev_kind = KIND_STRING;
                    end
                    PH_NUMBER:
                    begin
                        if (!is_digit(c)) begin
                            ev_done = 1'b1;
                            ev_kind = KIND_NUMBER;
                        end
                    end
                    PH_LITERAL:
                    begin
                        if (state_reg.lit_kind > LIT_NULL) begin
                            ev_fail = 1'b1;
                        end else if (state_reg.lit_index >= lit_len(state_reg.lit_kind)) begin
                            ev_done = 1'b1;
                            ev_kind = KIND_TRUE + {1'b0, state_reg.lit_kind};
                        end else if (c != lit_char(state_reg.lit_kind, state_reg.lit_index)) begin
                            ev_fail = 1'b1;
                        end else begin
                            li_new = state_reg.lit_index + 3'd1;
                        end
                    end
                    default:
                    begin
                        ev_fail = 1'b1;
                    end
                endcase
                // unfinished on the last buffer byte
                if (!ev_fail && !ev_done && !ev_open && (pos_inc >= blen)) begin
                    ev_fail = 1'b1;
                end
            end
        end
    end

    // next state
    always_comb
    begin
        state_next             = state_reg;
        state_next.phase       = (ev_fail || ev_done || ev_open) ? PH_IDLE : cont_phase;
        state_next.lit_kind    = lk_new;
        state_next.lit_index   = li_new;
        state_next.token_start = ts_new;
    end

    // result fields
    always_comb
    begin
        emit                 = ev_fail || ev_done || ev_open;
        result.scan_status   = STATUS_TOKEN;
        result.value_kind    = ev_kind;
        result.token_offset  = ts_new;
        result.token_length  = {1'b0, item.position - ts_new};
        result.resume_offset = item.position;
        if (ev_fail) begin
            result.scan_status   = STATUS_ERROR;
            result.value_kind    = KIND_STRING;
            result.token_offset  = 16'd0;
            result.token_length  = 17'd0;
            result.resume_offset = ts_new;
        end else if (ev_open) begin
            result.token_offset  = item.position;
            result.token_length  = blen - pos_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.phase       <= PH_IDLE;
            state_reg.lit_kind    <= LIT_TRUE;
            state_reg.lit_index   <= 3'd0;
            state_reg.token_start <= 16'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

endmodule

### design/jsts_out_reg.sv
// ----------------------------------------------------------------------------
// jsts_out_reg
// result register holding one finished token toward the downstream side
// ----------------------------------------------------------------------------
module jsts_out_reg
    import jsts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    room,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // free now, or emptied at this edge
    assign room = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (room) begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && load) begin
            data_reg <= load_data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

### design/json_scalar_token_scanner_unit.sv
// ----------------------------------------------------------------------------
// json_scalar_token_scanner_unit: one byte per cycle while the result register has room
// the step logic between input and result registers sets the one-byte-per-cycle rate
// reset clears the scan state and both valid flags; no clearing pass is needed
// ----------------------------------------------------------------------------
module json_scalar_token_scanner_unit
    import jsts_pkg::*;
#(
    parameter int BUFFER_BYTES = 65536
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // input register: one byte request waiting for the step logic
    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_data_reg;

    // step and result register handshake
    logic    advance;
    logic    room;
    logic    emit;
    result_t step_result;

    // a byte moves on only when the result register can take what it causes;
    // bytes with no result wait too, which keeps the order trivially intact
    assign advance    = in_valid_reg && room;

    // input side frees up whenever the held byte moves on this cycle
    assign item_stall = in_valid_reg && !advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!item_stall) begin
            in_valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall) begin
            in_data_reg <= item;
        end
    end

    // scan state and per-byte classification
    jsts_scan_fsm #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_data_reg),
        .emit    (emit),
        .result  (step_result)
    );

    // result register parts the downstream stall from the intake
    jsts_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && emit),
        .load_data    (step_result),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### design/jsts_checker.sv
// ----------------------------------------------------------------------------
// jsts_checker
// port-level checks on the token scanner results
// ----------------------------------------------------------------------------
module jsts_checker
    import jsts_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // error results carry no token
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.scan_status == STATUS_ERROR) |->
        (result.value_kind == KIND_STRING) && (result.token_offset == 16'd0) &&
        (result.token_length == 17'd0))
        else $error("error result with token fields");

    // containers resume at their opener
    a_open_resume: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.scan_status == STATUS_TOKEN) &&
        ((result.value_kind == KIND_OBJECT) || (result.value_kind == KIND_ARRAY)) |->
        (result.resume_offset == result.token_offset))
        else $error("container resume offset mismatch");

    // scalars resume right after the token
    a_scalar_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.scan_status == STATUS_TOKEN) &&
        (result.value_kind != KIND_OBJECT) && (result.value_kind != KIND_ARRAY) |->
        (result.token_length[16] == 1'b0) &&
        (16'(result.resume_offset - result.token_offset) == result.token_length[15:0]))
        else $error("scalar length disagrees with offsets");

endmodule

bind json_scalar_token_scanner_unit jsts_checker u_jsts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: regression for the json scalar token scanner
// sends buffer bytes with positions and lengths through the request channel,
// predicts every token report from its own scan state machine and compares
// each report field by field, under changing sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb;
    import jsts_pkg::*;

    // the unit clamps buffer_length to its buffer size
    localparam int         BUF_SIZE     = 65536;
    localparam int         LEN_MAX      = 131071;
    localparam int         QUIET_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         PRINT_LIMIT  = 40;
    // value_kind carried by an error report
    localparam logic [2:0] NO_KIND      = 3'd0;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    json_scalar_token_scanner_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // scanner state as the predictor sees it
    phase_t      sc_phase     = PH_IDLE;
    logic [1:0]  sc_lit_kind  = LIT_TRUE;
    logic [2:0]  sc_lit_idx   = 3'd0;
    logic [15:0] sc_tok_start = 16'd0;
    string       lit_words[3] = '{"true", "false", "null"};

    // token reports predicted but not yet seen on the result channel
    result_t     pending_tokens[$];
    result_t     want_tok;
    result_t     next_tok;

    // bytes of the run being built for the request channel
    logic [7:0]  tok_bytes[$];

    int          idle_pct     = 0;
    int          stall_pct    = 0;
    int          fail_count   = 0;
    int          bytes_sent   = 0;
    int          scan_bytes   = 0;
    int          ok_tokens    = 0;
    int          err_tokens   = 0;
    int          quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // closes the scan with one report
    function automatic bit end_scan(output result_t res, input logic st,
                                    input logic [2:0] kind, input logic [15:0] off,
                                    input logic [16:0] len, input logic [15:0] resume);
        res.scan_status   = st;
        res.value_kind    = kind;
        res.token_offset  = off;
        res.token_length  = len;
        res.resume_offset = resume;
        sc_phase = PH_IDLE;
        return 1'b1;
    endfunction

    // error: only resume_offset carries information, the last token start
    function automatic bit scan_error(output result_t res);
        return end_scan(res, STATUS_ERROR, NO_KIND, 16'd0, 17'd0, sc_tok_start);
    endfunction

    // token ended by the byte at pos; length wraps at 16 bits
    function automatic bit token_done(output result_t res, input logic [2:0] kind,
                                      input logic [15:0] pos);
        logic [15:0] span;
        span = pos - sc_tok_start;
        return end_scan(res, STATUS_TOKEN, kind, sc_tok_start, {1'b0, span}, pos);
    endfunction

    function automatic bit digit_char(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic bit hex_char(input logic [7:0] c);
        return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
    endfunction

    // advances the scan by one accepted byte; returns 1 when a report is due
    function automatic bit predict_token(input item_t it, output result_t res);
        int          blen;
        logic [15:0] pos;
        logic [7:0]  c;
        res  = '0;
        pos  = it.position;
        c    = it.byte_value;
        blen = (int'(it.buffer_length) > BUF_SIZE) ? BUF_SIZE : int'(it.buffer_length);

        // a start drops whatever scan was in progress
        if (it.start_scan)
        begin
            sc_phase     = PH_BLANK;
            sc_tok_start = pos;
        end
        if (sc_phase == PH_IDLE)
            return 1'b0;
        if (int'(pos) >= blen)
            return scan_error(res);

        case (sc_phase)
            PH_BLANK:
            begin
                sc_tok_start = pos;
                if (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})
                    ;
                else if (c == CH_LBRACE)
                    return end_scan(res, STATUS_TOKEN, KIND_OBJECT, pos, 17'(blen - pos), pos);
                else if (c == CH_LBRACK)
                    return end_scan(res, STATUS_TOKEN, KIND_ARRAY, pos, 17'(blen - pos), pos);
                else if (c == CH_QUOTE)
                    sc_phase = PH_STRING;
                else if (digit_char(c))
                    sc_phase = PH_NUMBER;
                else if (c inside {CH_LOWER_T, CH_LOWER_F, CH_LOWER_N})
                begin
                    sc_lit_kind = (c == CH_LOWER_T) ? LIT_TRUE :
                                  (c == CH_LOWER_F) ? LIT_FALSE : LIT_NULL;
                    sc_lit_idx  = 3'd1;
                    sc_phase    = PH_LITERAL;
                end
                else
                    return scan_error(res);
            end
            PH_STRING:
            begin
                if (c == CH_BSLASH)
                    sc_phase = PH_ESCAPE;
                else if (c == CH_QUOTE)
                    sc_phase = PH_STR_DONE;
            end
            PH_ESCAPE:
            begin
                if (c == CH_LOWER_U)
                    sc_phase = PH_HEX1;
                else if (c inside {CH_LOWER_B, CH_LOWER_F, CH_LOWER_T, CH_LOWER_R,
                                   CH_LOWER_N, CH_SLASH, CH_QUOTE, CH_BSLASH})
                    sc_phase = PH_STRING;
                else
                    return scan_error(res);
            end
            PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4:
            begin
                if (!hex_char(c))
                    return scan_error(res);
                sc_phase = (sc_phase == PH_HEX4) ? PH_STRING : phase_t'(sc_phase + 4'd1);
            end
            PH_STR_DONE:
                return token_done(res, KIND_STRING, pos);
            PH_NUMBER:
            begin
                if (!digit_char(c))
                    return token_done(res, KIND_NUMBER, pos);
            end
            PH_LITERAL:
            begin
                if (sc_lit_kind > LIT_NULL)
                    return scan_error(res);
                // the byte after the last letter ends the literal
                if (sc_lit_idx >= lit_words[sc_lit_kind].len())
                    return token_done(res, KIND_TRUE + sc_lit_kind, pos);
                if (c != lit_words[sc_lit_kind][sc_lit_idx])
                    return scan_error(res);
                sc_lit_idx = sc_lit_idx + 3'd1;
            end
            default:
                return scan_error(res);
        endcase

        // still open on the buffer's last byte: out of buffer
        if (int'(pos) + 1 >= blen)
            return scan_error(res);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("mismatch @%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // both channels are sampled at the rising edge; reports are handled
    // before the request of the same edge so a stray report cannot
    // borrow the expectation that this request creates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_tokens.size() == 0)
                    report_mismatch($sformatf("token report with none pending, offset %0d",
                                              result.token_offset));
                else
                begin
                    want_tok = pending_tokens.pop_front();
                    check_field("scan_status", result.scan_status, want_tok.scan_status);
                    check_field("value_kind", result.value_kind, want_tok.value_kind);
                    check_field("token_offset", result.token_offset, want_tok.token_offset);
                    check_field("token_length", result.token_length, want_tok.token_length);
                    check_field("resume_offset", result.resume_offset,
                                want_tok.resume_offset);
                end
            end
            if (item_valid && !item_stall)
            begin
                bytes_sent++;
                // bytes that reach an idle scanner without start are dropped
                if (item.start_scan || sc_phase != PH_IDLE)
                    scan_bytes++;
                if (predict_token(item, next_tok))
                begin
                    pending_tokens.push_back(next_tok);
                    if (next_tok.scan_status == STATUS_TOKEN)
                        ok_tokens++;
                    else
                        err_tokens++;
                end
            end
        end
    end

    // watchdog: a long stretch with no handshake on either side is a hang
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d reports pending",
                     quiet_cycles, pending_tokens.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver back-pressure
    always @(negedge clk)
        result_stall <= ($urandom_range(0, 99) < stall_pct);

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // entered and left at a falling edge; valid stays high on return so a
    // following request does not lower and raise it in the same step
    task automatic send_byte(input logic st, input logic [15:0] pos,
                             input logic [7:0] b, input logic [16:0] blen);
        item_t req;
        req.start_scan    = st;
        req.position      = pos;
        req.byte_value    = b;
        req.buffer_length = blen;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            tok_bytes.push_back(s[i]);
    endtask

    // sends the built run at consecutive positions, start on its first byte
    task automatic send_run(input int p, input int blen);
        for (int i = 0; i < tok_bytes.size(); i++)
            send_byte(i == 0, 16'(p + i), tok_bytes[i], 17'(blen));
        tok_bytes.delete();
    endtask

    // mostly well-formed values with random content, some of them broken
    task automatic build_random_token();
        int         sel;
        logic [7:0] ch;
        string      hex_set;
        hex_set = "0123456789abcdefABCDEF";
        tok_bytes.delete();
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 3))
                0:       tok_bytes.push_back(CH_SPACE);
                1:       tok_bytes.push_back(CH_TAB);
                2:       tok_bytes.push_back(CH_CR);
                default: tok_bytes.push_back(CH_LF);
            endcase
        end
        sel = $urandom_range(0, 99);
        if (sel < 10)
            tok_bytes.push_back(CH_LBRACE);
        else if (sel < 20)
            tok_bytes.push_back(CH_LBRACK);
        else if (sel < 45)
        begin
            tok_bytes.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 6))
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        tok_bytes.push_back(CH_BSLASH);
                        case ($urandom_range(0, 7))
                            0:       tok_bytes.push_back(CH_LOWER_B);
                            1:       tok_bytes.push_back(CH_LOWER_F);
                            2:       tok_bytes.push_back(CH_LOWER_T);
                            3:       tok_bytes.push_back(CH_LOWER_R);
                            4:       tok_bytes.push_back(CH_LOWER_N);
                            5:       tok_bytes.push_back(CH_SLASH);
                            6:       tok_bytes.push_back(CH_QUOTE);
                            default: tok_bytes.push_back(CH_BSLASH);
                        endcase
                    end
                    1:
                    begin
                        tok_bytes.push_back(CH_BSLASH);
                        tok_bytes.push_back(CH_LOWER_U);
                        repeat (4)
                            tok_bytes.push_back(hex_set[$urandom_range(0, 21)]);
                    end
                    default:
                    begin
                        do
                            ch = $urandom_range(32, 255);
                        while (ch == CH_QUOTE || ch == CH_BSLASH);
                        tok_bytes.push_back(ch);
                    end
                endcase
            end
            tok_bytes.push_back(CH_QUOTE);
        end
        else if (sel < 65)
        begin
            repeat ($urandom_range(1, 6))
                tok_bytes.push_back($urandom_range("0", "9"));
        end
        else if (sel < 88)
            push_text(lit_words[$urandom_range(0, 2)]);
        else
            tok_bytes.push_back($urandom_range(0, 255));

        // the byte that ends the token
        case ($urandom_range(0, 5))
            0:       tok_bytes.push_back(",");
            1:       tok_bytes.push_back("}");
            2:       tok_bytes.push_back("]");
            3:       tok_bytes.push_back(CH_SPACE);
            4:       tok_bytes.push_back(":");
            default: tok_bytes.push_back($urandom_range(0, 255));
        endcase

        // a broken value: one byte replaced by anything
        if ($urandom_range(0, 9) == 0)
            tok_bytes[$urandom_range(1, tok_bytes.size() - 1)] = $urandom_range(0, 255);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // no scan open, no start: the byte is dropped
    task automatic test_idle_bytes();
        send_byte(1'b0, 16'd100, "x", 17'd200);
    endtask

    // openers report at once; lengths at both ends of the buffer
    task automatic test_containers();
        push_text("{");
        send_run(0, LEN_MAX);          // clamped length, full buffer
        push_text("\t[");
        send_run(65534, BUF_SIZE);     // opener on the last byte
    endtask

    // \u escape with mixed hex case, closed and reported on the comma
    task automatic test_strings();
        push_text("\"\\u0aF9\",");
        send_run(1000, 2000);
    endtask

    // a number whose end byte lies before its start: length wraps
    task automatic test_numbers();
        send_byte(1'b1, 16'd10, "5", 17'd100);
        send_byte(1'b0, 16'd3, ",", 17'd100);
    endtask

    task automatic test_literals();
        push_text("null]");
        send_run(40000, 40100);
        // literal complete exactly at the buffer end: out of buffer
        push_text("true");
        send_run(500, 504);
    endtask

    task automatic test_errors();
        push_text("#");
        send_run(7, 9);                // bad first byte
        send_byte(1'b1, 16'd50, "7", 17'd50);   // position at the length
        push_text("\"");               // string dropped by a new start
        send_run(60, 90);
        push_text("7 ");
        send_run(61, 90);
    endtask

    task automatic test_random_stream();
        int p;
        int blen;
        int target;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 62; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            target = scan_bytes + 500;
            while (scan_bytes < target)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    // noise: any start bit, position, byte and length
                    repeat ($urandom_range(1, 4))
                        send_byte($urandom_range(0, 1), $urandom_range(0, 65535),
                                  $urandom_range(0, 255), $urandom_range(0, LEN_MAX));
                end
                else
                begin
                    build_random_token();
                    // a few runs start near the top and wrap their positions
                    if ($urandom_range(0, 19) == 0)
                        p = 65535 - $urandom_range(0, 3);
                    else
                        p = $urandom_range(0, 65000);
                    case ($urandom_range(0, 9))
                        0, 1:    blen = p + $urandom_range(0, tok_bytes.size());
                        2, 3:    blen = $urandom_range(BUF_SIZE, LEN_MAX);
                        4:       blen = $urandom_range(0, LEN_MAX);
                        default: blen = p + tok_bytes.size() + $urandom_range(0, 300);
                    endcase
                    if (blen > LEN_MAX)
                        blen = LEN_MAX;
                    send_run(p, blen);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_bytes();
        test_containers();
        test_strings();
        test_numbers();
        test_literals();
        test_errors();
        test_random_stream();

        // stop sending, open the receiver and let every report drain
        item_valid <= 1'b0;
        stall_pct = 0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("sent %0d bytes, %0d of them inside scans, four idle/stall mixes",
                 bytes_sent, scan_bytes);
        $display("checked %0d tokens and %0d error reports, %0d mismatches",
                 ok_tokens, err_tokens, fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
design/jsts_pkg.sv
design/jsts_scan_fsm.sv
design/jsts_out_reg.sv
design/json_scalar_token_scanner_unit.sv
design/jsts_checker.sv
tb/tb.sv
